@@ rtl/gradient_noise_2d_macros.svh @@
// Assertion macros used by the checker file.
`ifndef GRADIENT_NOISE_2D_MACROS_SVH
`define GRADIENT_NOISE_2D_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define GN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gradient noise check failed");
// Next-cycle implication checked outside reset.
`define GN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gradient noise check failed");
`endif

@@ rtl/gn2d_pkg.sv @@
// Package with constants and gradient helpers for the gradient noise block.
`timescale 1ns / 1ps
package gn2d_pkg;
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int COORD_W         = 32;
    localparam int OUT_W           = 18;
    localparam int ENTRY_W         = 8;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    // Gradient index h mod 12: the two low bits pass through and the upper six
    // bits are reduced mod 3 by compare and subtract.
    function automatic logic [3:0] grad_sel(input logic [7:0] h);
        logic [5:0] r;
        r = h[7:2];
        for (int k = 4; k >= 0; k--)
        begin
            if (r >= 6'(3 << k))
            begin
                r = r - 6'(3 << k);
            end
        end
        grad_sel = {r[1:0], h[1:0]};
    endfunction

    // Gradient x and y component for hash value h (h mod 12 taken inside).
    function automatic logic signed [1:0] grad_x(input logic [7:0] h);
        logic [3:0] g;
        g = grad_sel(h);
        case (g)
            4'd6, 4'd7: grad_x = 2'sd0;
            4'd0, 4'd2, 4'd4, 4'd8, 4'd10: grad_x = 2'sd1;
            default: grad_x = -2'sd1;
        endcase
    endfunction

    function automatic logic signed [1:0] grad_y(input logic [7:0] h);
        logic [3:0] g;
        g = grad_sel(h);
        case (g)
            4'd4, 4'd5: grad_y = 2'sd0;
            4'd0, 4'd1, 4'd6, 4'd8, 4'd9: grad_y = 2'sd1;
            default: grad_y = -2'sd1;
        endcase
    endfunction
endpackage

@@ rtl/gn2d_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
`timescale 1ns / 1ps
module gn2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

@@ rtl/gn2d_front.sv @@
// Front end: takes input beats, writes the table on loads, queues evaluations.
`timescale 1ns / 1ps
module gn2d_front #(
    parameter int TABLE_DEPTH = gn2d_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                valid,
    output logic                                ready,
    input  logic                                kind,
    input  logic [gn2d_pkg::ENTRY_W-1:0]        entry_index,
    input  logic [gn2d_pkg::ENTRY_W-1:0]        entry_value,
    input  logic signed [gn2d_pkg::COORD_W-1:0] coord_x,
    input  logic signed [gn2d_pkg::COORD_W-1:0] coord_y,
    input  logic                                tbl_busy,
    output logic                                tbl_we,
    output logic [$clog2(TABLE_DEPTH)-1:0]      tbl_waddr,
    output logic [gn2d_pkg::ENTRY_W-1:0]        tbl_wdata,
    output logic                                q_valid,
    input  logic                                q_ready,
    output logic signed [gn2d_pkg::COORD_W-1:0] q_x,
    output logic signed [gn2d_pkg::COORD_W-1:0] q_y
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int QD = 2;

    logic signed [gn2d_pkg::COORD_W-1:0] qx_reg [QD];
    logic signed [gn2d_pkg::COORD_W-1:0] qy_reg [QD];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       acc, push, pop;

    // A load waits until no earlier evaluation still has to read the table.
    assign ready = (cnt_reg != 2'(QD))
                   && ((kind == gn2d_pkg::KIND_EVAL) || ((cnt_reg == 2'd0) && !tbl_busy));
    assign acc   = valid && ready;
    assign push  = acc && (kind == gn2d_pkg::KIND_EVAL);
    assign pop   = q_valid && q_ready;

    assign tbl_we    = acc && (kind == gn2d_pkg::KIND_LOAD)
                       && ({24'b0, entry_index} < 32'(TABLE_DEPTH));
    assign tbl_waddr = AW'(entry_index);
    assign tbl_wdata = entry_value;

    assign q_valid = (cnt_reg != 2'd0);
    assign q_x     = qx_reg[rp_reg];
    assign q_y     = qy_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            qx_reg[wp_reg] <= coord_x;
            qy_reg[wp_reg] <= coord_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

@@ rtl/gn2d_back.sv @@
// Back end: hash lookup, fade, dot products and interpolation pipeline.
`timescale 1ns / 1ps
module gn2d_back #(
    parameter int TABLE_DEPTH = gn2d_pkg::TABLE_DEPTH_DEF,
    parameter int FRAC_BITS   = gn2d_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                tbl_we,
    input  logic [$clog2(TABLE_DEPTH)-1:0]      tbl_waddr,
    input  logic [gn2d_pkg::ENTRY_W-1:0]        tbl_wdata,
    output logic                                tbl_busy,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [gn2d_pkg::COORD_W-1:0] in_x,
    input  logic signed [gn2d_pkg::COORD_W-1:0] in_y,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [gn2d_pkg::OUT_W-1:0]   out_noise
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int F  = FRAC_BITS;
    localparam int NS = 7;           // pipeline stages
    localparam int DW = F + 3;       // dot / lerp width
    localparam int PW = 2 * F + 8;   // product width
    localparam logic signed [PW-1:0]   HALF      = PW'(1) <<< (F - 1);
    localparam logic signed [DW+1:0]   ONE_Q     = (DW+2)'(1) <<< F;
    localparam logic signed [DW+1:0]   FIFTEEN_Q = (DW+2)'(15) <<< F;
    localparam logic signed [DW+1:0]   TEN_Q     = (DW+2)'(10) <<< F;

    typedef struct packed {
        logic [F-1:0]    fx;
        logic [F-1:0]    fy;
        logic [AW-1:0]   cx0;
        logic [AW-1:0]   cy0;
        logic [AW-1:0]   cy1;
    } crd_t;

    logic          adv;
    logic [NS-1:0] v_reg;
    crd_t          c_reg [3];
    logic [gn2d_pkg::ENTRY_W-1:0] pa0, pa1, ha0, hb0, ha1, hb1;
    logic [AW-1:0] cx1;
    logic [AW-1:0] a00, a01, a10, a11;
    logic [AW-1:0] s00_reg, s01_reg, s10_reg, s11_reg;
    logic [AW-1:0] h00a, h01a, h10a, h11a;
    logic signed [DW+1:0] fx0, fy0, fxs, fys, fxm, fym;
    logic signed [DW+1:0] tq_x_reg, tq_y_reg, tt_x_reg, tt_y_reg;
    logic signed [DW+1:0] inr_x_reg, inr_y_reg, inr_x2_reg, inr_y2_reg;
    logic signed [DW+1:0] t3_x_reg, t3_y_reg, u_reg, w_reg, w_hold_reg;
    logic signed [DW+1:0] d_reg [4];
    logic signed [DW+1:0] l0_reg, l1_reg, res_reg;
    logic signed [DW+17:0] sc;
    logic signed [gn2d_pkg::OUT_W-1:0] o_reg;

    // Stage enable: the whole pipe advances unless its tail is stuck.
    assign adv       = !out_valid || out_ready;
    assign in_ready  = adv;
    assign out_valid = v_reg[NS-1];
    // Stages 0 to 2 still read the table.
    assign tbl_busy  = |v_reg[2:0];

    // Rounded Q.F product of two signed values.
    function automatic logic signed [DW+1:0] rmul(input logic signed [DW+1:0] a,
                                                  input logic signed [DW+1:0] b);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b) + HALF;
        rmul = (DW+2)'(p >>> F);
    endfunction

    // Inner factor of the fade, t * (6t - 15) + 10.
    function automatic logic signed [DW+1:0] fade_inner(input logic signed [DW+1:0] t);
        logic signed [DW+1:0] lin;
        lin = (t <<< 2) + (t <<< 1) - FIFTEEN_Q;
        fade_inner = rmul(t, lin) + TEN_Q;
    endfunction

    function automatic logic signed [DW+1:0] dotp(input logic [7:0] h,
                                                  input logic signed [DW+1:0] dx,
                                                  input logic signed [DW+1:0] dy);
        logic signed [1:0] gx, gy;
        logic signed [DW+1:0] tx, ty;
        gx = gn2d_pkg::grad_x(h);
        gy = gn2d_pkg::grad_y(h);
        tx = (gx == 2'sd0) ? '0 : ((gx == 2'sd1) ? dx : -dx);
        ty = (gy == 2'sd0) ? '0 : ((gy == 2'sd1) ? dy : -dy);
        dotp = tx + ty;
    endfunction

    // Stage 0: split coordinates; later stages carry them along.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_reg[0].fx  <= in_x[F-1:0];
            c_reg[0].fy  <= in_y[F-1:0];
            c_reg[0].cx0 <= in_x[F +: AW];
            c_reg[0].cy0 <= in_y[F +: AW];
            c_reg[0].cy1 <= in_y[F +: AW] + 1'b1;
            c_reg[1]     <= c_reg[0];
            c_reg[2]     <= c_reg[1];
        end
    end

    // First table level reads px0 and px1; a stall re-reads the held addresses.
    assign cx1 = c_reg[0].cx0 + 1'b1;

    gn2d_ram #(.WIDTH(gn2d_pkg::ENTRY_W), .DEPTH(TABLE_DEPTH)) u_perm0 (
        .clk, .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
        .raddr_a(adv ? c_reg[0].cx0 : c_reg[1].cx0), .rdata_a(pa0),
        .raddr_b(adv ? cx1 : AW'(c_reg[1].cx0 + 1'b1)), .rdata_b(pa1)
    );

    // Stage 1 addresses: hash of the four corners.
    assign a00 = AW'(pa0) + c_reg[1].cy0;
    assign a01 = AW'(pa0) + c_reg[1].cy1;
    assign a10 = AW'(pa1) + c_reg[1].cy0;
    assign a11 = AW'(pa1) + c_reg[1].cy1;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s00_reg <= a00;
            s01_reg <= a01;
            s10_reg <= a10;
            s11_reg <= a11;
        end
    end
    assign h00a = adv ? a00 : s00_reg;
    assign h01a = adv ? a01 : s01_reg;
    assign h10a = adv ? a10 : s10_reg;
    assign h11a = adv ? a11 : s11_reg;

    gn2d_ram #(.WIDTH(gn2d_pkg::ENTRY_W), .DEPTH(TABLE_DEPTH)) u_perm1 (
        .clk, .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
        .raddr_a(h00a), .rdata_a(ha0), .raddr_b(h10a), .rdata_b(hb0)
    );
    gn2d_ram #(.WIDTH(gn2d_pkg::ENTRY_W), .DEPTH(TABLE_DEPTH)) u_perm2 (
        .clk, .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
        .raddr_a(h01a), .rdata_a(ha1), .raddr_b(h11a), .rdata_b(hb1)
    );

    assign fx0 = (DW+2)'({1'b0, c_reg[0].fx});
    assign fy0 = (DW+2)'({1'b0, c_reg[0].fy});
    assign fxs = (DW+2)'({1'b0, c_reg[2].fx});
    assign fys = (DW+2)'({1'b0, c_reg[2].fy});
    assign fxm = fxs - ONE_Q;
    assign fym = fys - ONE_Q;

    // Fade runs beside the lookups: stage 1 t*t and the inner factor, stage 2
    // t^3, stage 3 the fade. Stage 3 also forms the exact dots, stage 4 the
    // horizontal lerps and stage 5 the vertical lerp.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tq_x_reg   <= rmul(fx0, fx0);
            tq_y_reg   <= rmul(fy0, fy0);
            tt_x_reg   <= fx0;
            tt_y_reg   <= fy0;
            inr_x_reg  <= fade_inner(fx0);
            inr_y_reg  <= fade_inner(fy0);
            t3_x_reg   <= rmul(tq_x_reg, tt_x_reg);
            t3_y_reg   <= rmul(tq_y_reg, tt_y_reg);
            inr_x2_reg <= inr_x_reg;
            inr_y2_reg <= inr_y_reg;
            u_reg      <= rmul(t3_x_reg, inr_x2_reg);
            w_reg      <= rmul(t3_y_reg, inr_y2_reg);
            d_reg[0]   <= dotp(ha0, fxs, fys);
            d_reg[1]   <= dotp(hb0, fxm, fys);
            d_reg[2]   <= dotp(ha1, fxs, fym);
            d_reg[3]   <= dotp(hb1, fxm, fym);
            l0_reg     <= d_reg[0] + rmul(u_reg, d_reg[1] - d_reg[0]);
            l1_reg     <= d_reg[2] + rmul(u_reg, d_reg[3] - d_reg[2]);
            w_hold_reg <= w_reg;
            res_reg    <= l0_reg + rmul(w_hold_reg, l1_reg - l0_reg);
        end
    end

    // Scaling to Q.16 and saturation in stage 6.
    always_comb
    begin
        if (F < 16)
            sc = (DW+18)'(res_reg) <<< ((16 - F) & 15);
        else if (F > 16)
            sc = ((DW+18)'(res_reg) + ((DW+18)'(1) <<< ((F - 17) & 31)))
                 >>> ((F - 16) & 31);
        else
            sc = (DW+18)'(res_reg);
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (sc > (DW+18)'(131071)) o_reg <= 18'sd131071;
            else if (sc < -(DW+18)'(131072)) o_reg <= -18'sd131072;
            else o_reg <= gn2d_pkg::OUT_W'(sc);
        end
    end
    assign out_noise = o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end
endmodule

@@ rtl/gradient_noise_2d.sv @@
// Top level of the 2D gradient noise evaluator.
// Path: an evaluate beat that is taken waits in the two-entry queue and then passes
// the back-end pipeline before out_valid rises; output stalls hold it longer.
// Throughput: one evaluate beat per cycle while the queue is not full; a load beat
// waits until no evaluation still reads the table.
// Reset (rst_n, asynchronous) clears the queue and pipeline valid bits only.
`timescale 1ns / 1ps
module gradient_noise_2d #(
    parameter int TABLE_DEPTH = gn2d_pkg::TABLE_DEPTH_DEF,
    parameter int FRAC_BITS   = gn2d_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic [gn2d_pkg::ENTRY_W-1:0]        entry_index,
    input  logic [gn2d_pkg::ENTRY_W-1:0]        entry_value,
    input  logic signed [gn2d_pkg::COORD_W-1:0] coord_x,
    input  logic signed [gn2d_pkg::COORD_W-1:0] coord_y,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [gn2d_pkg::OUT_W-1:0]   noise_value
);
    localparam int AW = $clog2(TABLE_DEPTH);

    logic                 we;
    logic [AW-1:0]        waddr;
    logic [gn2d_pkg::ENTRY_W-1:0] wdata;
    logic                 busy;
    logic                 qv, qr;
    logic signed [gn2d_pkg::COORD_W-1:0] qx, qy;

    // Front end classifies beats; evaluations wait in a short queue. A load
    // beat is held back while the back end still has evaluations that read the
    // table, so every evaluation sees the table as it stood when it was taken.
    gn2d_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
        .clk, .rst_n, .valid(in_valid), .ready(in_ready), .kind, .entry_index,
        .entry_value, .coord_x, .coord_y, .tbl_busy(busy), .tbl_we(we),
        .tbl_waddr(waddr), .tbl_wdata(wdata), .q_valid(qv), .q_ready(qr),
        .q_x(qx), .q_y(qy)
    );

    // Back end computes the noise value.
    gn2d_back #(.TABLE_DEPTH(TABLE_DEPTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk, .rst_n, .tbl_we(we), .tbl_waddr(waddr), .tbl_wdata(wdata),
        .tbl_busy(busy), .in_valid(qv), .in_ready(qr), .in_x(qx), .in_y(qy),
        .out_valid, .out_ready, .out_noise(noise_value)
    );
endmodule

@@ rtl/gn2d_checker.sv @@
// Port-level checker for the gradient noise block, with its bind.
`timescale 1ns / 1ps
`include "gradient_noise_2d_macros.svh"
module gn2d_checker (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [17:0] noise_value
);
    `GN_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `GN_ASSERT_NEXT(a_data_hold, clk, rst_n, out_valid && !out_ready, $stable(noise_value))
    `GN_ASSERT_IMP(a_ready_known, clk, rst_n, 1'b1, !$isunknown(in_ready))
endmodule

bind gradient_noise_2d gn2d_checker u_gn2d_checker (
    .clk, .rst_n, .in_ready, .out_valid, .out_ready, .noise_value
);
